// ===== rtl/kmth_pkg.sv =====
// Package for the keyword mix-table hash block.
// Types, register indexes, mode codes and hash constants. No dependencies.
package kmth_pkg;
  localparam logic [1:0] MODE_PEARSON = 2'd0;
  localparam logic [1:0] MODE_CRC32   = 2'd1;
  localparam logic [1:0] MODE_FNV32   = 2'd2;
  localparam logic [1:0] MODE_FNV64   = 2'd3;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_SLOTS = 3'd1;
  localparam logic [2:0] REG_MIX0  = 3'd2;
  localparam logic [2:0] REG_MIX1  = 3'd3;
  localparam logic [2:0] REG_MIX2  = 3'd4;
  localparam logic [2:0] REG_MIX3  = 3'd5;

  localparam logic [31:0] FNV32_BASIS = 32'h811c9dc5;
  localparam logic [31:0] FNV32_PRIME = 32'h01000193;
  localparam logic [63:0] FNV64_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV64_PRIME = 64'h00000100000001B3;
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       key_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] slot;
    logic [7:0] hash_byte;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [63:0] data;
  } cfg_item_t;
endpackage

// ===== rtl/kmth_if.sv =====
// Valid/ready channel interfaces for the keyword mix-table hash block.
// Depends on kmth_pkg.
interface kmth_in_if;
  logic valid;
  logic ready;
  kmth_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kmth_out_if;
  logic valid;
  logic ready;
  kmth_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kmth_cfg_if;
  logic valid;
  logic ready;
  kmth_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/kmth_mul.sv =====
// Shared 32x32 multiplier with registered product for FNV updates.
// No dependencies.
module kmth_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);
  // product register
  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end
endmodule

// ===== rtl/keyword_mix_table_hash_top.sv =====
// Keyword mix-table hash block, top level.
// Depends on kmth_pkg, kmth_if and kmth_mul.
//
// Usage: keyword bytes come in on the input channel one item at a time;
// key_last marks the final byte. Only the final byte yields an output item
// carrying hash_byte and slot = hash_byte mod slot_count. Registers are
// written on the configuration channel (index 0 mode, 1 slot count,
// 2..5 mix words); cfg.ready is high only while the block is idle.
// A byte is taken only in the idle state, so the next byte waits until the last one is
// through its update: a mix-table lookup in Pearson mode, 4 CRC bits per cycle in CRC
// mode, a multiply in FNV-32 mode, and in FNV-64 mode the shared registered 32x32
// multiplier forms the 64-bit product from three partials.
// Last byte: a load step, then the fold xors in one mix entry per chunk until nothing
// is left (none in Pearson mode; at the default MIX_SIZE up to 7 chunks for 32-bit
// values, 13 for 64-bit), then restoring remainder steps, one per hash bit, form the slot.
// The result sits in an output register; while the receiver stalls no new
// byte and no register write is taken.
// Reset: mode 0, slot count 1, mix table zero, next byte starts a key.
module keyword_mix_table_hash_top #(
  parameter int MIX_SIZE = 32
) (
  input  logic clk,
  input  logic rst,
  kmth_in_if.sink    in_ch,
  kmth_out_if.source out_ch,
  kmth_cfg_if.sink   cfg
);
  localparam int MASKV = (MIX_SIZE - 1) & 31;
  localparam int BITS = (MASKV >= 16) ? 5 : (MASKV >= 8) ? 4 : (MASKV >= 4) ? 3 :
                        (MASKV >= 2) ? 2 : 1;
  localparam logic [4:0] MASK = 5'(MASKV);

  localparam logic [3:0] S_IDLE = 4'd0, S_UPD = 4'd1, S_CRC = 4'd2, S_M0 = 4'd3,
                         S_M1 = 4'd4, S_M2 = 4'd5, S_M3 = 4'd6, S_LOAD = 4'd7,
                         S_FOLD = 4'd8, S_MOD = 4'd9, S_OUT = 4'd10;

  logic [1:0]   hash_mode;
  logic [8:0]   slot_count;
  logic [255:0] mix;
  logic [3:0]   state;
  logic         at_key_start;
  logic [63:0]  running_hash;
  logic [7:0]   cur_byte;
  logic         cur_last;
  logic [63:0]  fold_val;
  logic [63:0]  acc;
  logic [7:0]   h;
  logic [7:0]   rem;
  logic [2:0]   mod_cnt;
  logic [8:0]   mod_t;
  logic [31:0]  ma, mb;
  logic [63:0]  mp;
  logic [63:0]  seed;
  logic [63:0]  x;
  logic [31:0]  crc_v;
  logic [4:0]   midx;
  logic [7:0]   mix_sel;

  kmth_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  assign cfg.ready = (state == S_IDLE);
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data.slot = rem;
  assign out_ch.data.hash_byte = h;

  // seed for a new key
  always_comb begin
    case (hash_mode)
      kmth_pkg::MODE_PEARSON: seed = 64'hFF;
      kmth_pkg::MODE_CRC32:   seed = 64'hFFFF_FFFF;
      kmth_pkg::MODE_FNV32:   seed = {32'd0, kmth_pkg::FNV32_BASIS};
      default:                seed = kmth_pkg::FNV64_BASIS;
    endcase
  end

  assign x = running_hash ^ {56'd0, cur_byte};

  // multiplier operand select; FNV-64 partials work on the xored value
  always_comb begin
    case (state)
      S_M0: begin ma = running_hash[31:0]; mb = kmth_pkg::FNV64_PRIME[31:0]; end
      S_M1: begin ma = running_hash[63:32]; mb = kmth_pkg::FNV64_PRIME[31:0]; end
      S_M2: begin ma = running_hash[31:0]; mb = kmth_pkg::FNV64_PRIME[63:32]; end
      default: begin ma = x[31:0]; mb = kmth_pkg::FNV32_PRIME; end
    endcase
  end

  // four CRC bit steps; the byte is xored in on the first pass
  always_comb begin
    crc_v = (state == S_UPD) ? x[31:0] : running_hash[31:0];
    for (int k = 0; k < 4; k++) begin
      crc_v = crc_v[0] ? ((crc_v >> 1) ^ kmth_pkg::CRC_POLY) : (crc_v >> 1);
    end
  end

  assign midx = (state == S_UPD) ? (cur_byte[4:0] & MASK) : (fold_val[4:0] & MASK);
  assign mix_sel = mix[{midx, 3'd0} +: 8];

  // next partial remainder input: shift in the next hash bit
  assign mod_t = {rem, h[mod_cnt]};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_mode <= kmth_pkg::MODE_PEARSON;
      slot_count <= 9'd1;
      mix <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.data.index)
        kmth_pkg::REG_MODE:  hash_mode <= cfg.data.data[1:0];
        kmth_pkg::REG_SLOTS: slot_count <= cfg.data.data[8:0];
        kmth_pkg::REG_MIX0:  mix[63:0] <= cfg.data.data;
        kmth_pkg::REG_MIX1:  mix[127:64] <= cfg.data.data;
        kmth_pkg::REG_MIX2:  mix[191:128] <= cfg.data.data;
        kmth_pkg::REG_MIX3:  mix[255:192] <= cfg.data.data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      at_key_start <= 1'b1;
      running_hash <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_ch.valid) begin
          cur_byte <= in_ch.data.key_byte;
          cur_last <= in_ch.data.key_last;
          if (at_key_start) running_hash <= seed;
          at_key_start <= 1'b0;
          state <= S_UPD;
        end
        S_UPD: begin
          case (hash_mode)
            kmth_pkg::MODE_PEARSON: begin
              running_hash <= {56'd0, running_hash[7:0] ^ mix_sel};
              state <= cur_last ? S_LOAD : S_IDLE;
            end
            kmth_pkg::MODE_CRC32: begin
              running_hash <= {32'd0, crc_v};
              state <= S_CRC;
            end
            kmth_pkg::MODE_FNV32: state <= S_M3;
            default: begin
              running_hash <= x;
              state <= S_M0;
            end
          endcase
        end
        // second half of the CRC byte
        S_CRC: begin
          running_hash <= {32'd0, crc_v};
          state <= cur_last ? S_LOAD : S_IDLE;
        end
        // FNV-64: lo*Plo + ((hi*Plo + lo*Phi) << 32)
        S_M0: state <= S_M1;
        S_M1: begin
          acc <= mp;
          state <= S_M2;
        end
        S_M2: begin
          acc[63:32] <= acc[63:32] + mp[31:0];
          state <= S_M3;
        end
        S_M3: begin
          if (hash_mode == kmth_pkg::MODE_FNV32)
            running_hash <= {32'd0, mp[31:0]};
          else
            running_hash <= {acc[63:32] + mp[31:0], acc[31:0]};
          state <= cur_last ? S_LOAD : S_IDLE;
        end
        // end of key: pick the value to fold, rearm for the next key
        S_LOAD: begin
          case (hash_mode)
            kmth_pkg::MODE_PEARSON: begin
              h <= running_hash[7:0];
              fold_val <= '0;
            end
            kmth_pkg::MODE_CRC32: begin
              h <= 8'd0;
              fold_val <= {32'd0, ~running_hash[31:0]};
            end
            kmth_pkg::MODE_FNV32: begin
              h <= 8'd0;
              fold_val <= {32'd0, running_hash[31:0]};
            end
            default: begin
              h <= 8'd0;
              fold_val <= running_hash;
            end
          endcase
          rem <= 8'd0;
          mod_cnt <= 3'd7;
          at_key_start <= 1'b1;
          running_hash <= '0;
          state <= (hash_mode == kmth_pkg::MODE_PEARSON) ? S_MOD : S_FOLD;
        end
        // one chunk per cycle until nothing is left
        S_FOLD: begin
          if (fold_val != 64'd0) begin
            h <= h ^ mix_sel;
            fold_val <= fold_val >> BITS;
          end else begin
            state <= S_MOD;
          end
        end
        // restoring remainder, MSB first; slot count zero passes the hash
        S_MOD: begin
          if (slot_count != 9'd0 && mod_t >= slot_count)
            rem <= 8'(mod_t - slot_count);
          else
            rem <= mod_t[7:0];
          mod_cnt <= mod_cnt - 3'd1;
          if (mod_cnt == 3'd0) state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
